>>> rtl/rlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_pkg
// Types and codes shared by the RLC PDU header parser modules.
// ----------------------------------------------------------------------------
package rlc_pkg;

  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       start_of_pdu;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [1:0]  pdu_kind;
    logic [11:0] seq_number;
    logic        poll_flag;
    logic [1:0]  header_extension;
    logic [6:0]  length_indicator;
    logic [1:0]  li_class;
    logic        ext_flag;
    logic [2:0]  control_type;
    logic [3:0]  sufi_type;
    logic        header_invalid;
  } out_item_t;

  // octet roles
  localparam logic [2:0] ROLE_FIRST      = 3'd0;
  localparam logic [2:0] ROLE_AM_SECOND  = 3'd1;
  localparam logic [2:0] ROLE_LI         = 3'd2;
  localparam logic [2:0] ROLE_PAYLOAD    = 3'd3;
  localparam logic [2:0] ROLE_CTRL_BODY  = 3'd4;
  localparam logic [2:0] ROLE_UNEXPECTED = 3'd5;

  // PDU kinds
  localparam logic [1:0] KIND_UM_DATA    = 2'd0;
  localparam logic [1:0] KIND_AM_DATA    = 2'd1;
  localparam logic [1:0] KIND_AM_CTRL    = 2'd2;

  // length indicator classes
  localparam logic [1:0] LIC_ORDINARY    = 2'd0;
  localparam logic [1:0] LIC_RESERVED    = 2'd1;
  localparam logic [1:0] LIC_PIGGYBACK   = 2'd2;
  localparam logic [1:0] LIC_PADDING     = 2'd3;

  localparam logic [6:0] LI_RESERVED     = 7'd125;
  localparam logic [6:0] LI_PIGGYBACK    = 7'd126;
  localparam logic [6:0] LI_PADDING      = 7'd127;

  // header extension codes
  localparam logic [1:0] HE_PAYLOAD      = 2'd0;
  localparam logic [1:0] HE_LI           = 2'd1;

  // control PDU types
  localparam logic [2:0] CT_STATUS       = 3'd0;
  localparam logic [2:0] CT_RESET_ACK    = 3'd2;

  // mode register
  localparam logic       MODE_UM         = 1'b0;
  localparam logic       MODE_AM         = 1'b1;

endpackage

>>> rtl/rlc_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_in_reg
// Input register stage: holds one octet until the decode stage takes it.
// ----------------------------------------------------------------------------
module rlc_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rlc_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rlc_pkg::in_item_t out_item_o
);

  logic              valid_q;
  rlc_pkg::in_item_t item_q;
  logic              load;

  // full and blocked downstream: hold
  assign in_stall_o = valid_q && out_stall_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

>>> rtl/rlc_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_decode
// Header decode: tags one octet and advances the parse phase on each transfer.
// ----------------------------------------------------------------------------
module rlc_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic               rlc_mode_i,
  input  rlc_pkg::in_item_t  item_i,
  output rlc_pkg::out_item_t result_o
);

  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_AM2     = 3'd1;
  localparam logic [2:0] PH_LI      = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CTRL    = 3'd4;
  localparam logic [2:0] PH_BAD     = 3'd5;

  logic [2:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic [1:0] kind_q, kind_d;

  logic [7:0]  b;
  logic [15:0] hdr;
  logic [2:0]  ct;
  logic [6:0]  li;

  assign b   = item_i.pdu_byte;
  assign hdr = {held_q, b};
  assign ct  = b[6:4];
  assign li  = b[7:1];

  always_comb begin
    result_o = '0;
    phase_d  = phase_q;
    held_d   = held_q;
    kind_d   = kind_q;

    if (item_i.start_of_pdu) begin
      result_o.byte_role = rlc_pkg::ROLE_FIRST;
      held_d = b;
      if (rlc_mode_i == rlc_pkg::MODE_UM) begin
        kind_d = rlc_pkg::KIND_UM_DATA;
        result_o.seq_number = {5'd0, li};
        result_o.ext_flag   = b[0];
        phase_d = b[0] ? PH_LI : PH_PAYLOAD;
      end else if (b[7]) begin
        kind_d  = rlc_pkg::KIND_AM_DATA;
        phase_d = PH_AM2;
      end else begin
        kind_d = rlc_pkg::KIND_AM_CTRL;
        result_o.control_type = ct;
        if (ct == rlc_pkg::CT_STATUS) begin
          result_o.sufi_type = b[3:0];
        end
        if (ct > rlc_pkg::CT_RESET_ACK) begin
          result_o.header_invalid = 1'b1;
          phase_d = PH_BAD;
        end else begin
          phase_d = PH_CTRL;
        end
      end
    end else begin
      unique case (phase_q)
        PH_AM2: begin
          result_o.byte_role        = rlc_pkg::ROLE_AM_SECOND;
          result_o.seq_number       = hdr[14:3];
          result_o.poll_flag        = hdr[2];
          result_o.header_extension = b[1:0];
          if (b[1:0] == rlc_pkg::HE_PAYLOAD) begin
            phase_d = PH_PAYLOAD;
          end else if (b[1:0] == rlc_pkg::HE_LI) begin
            phase_d = PH_LI;
          end else begin
            result_o.header_invalid = 1'b1;
            phase_d = PH_BAD;
          end
        end
        PH_LI: begin
          result_o.byte_role        = rlc_pkg::ROLE_LI;
          result_o.length_indicator = li;
          result_o.ext_flag         = b[0];
          if (li == rlc_pkg::LI_RESERVED) begin
            result_o.li_class = rlc_pkg::LIC_RESERVED;
          end else if (li == rlc_pkg::LI_PIGGYBACK) begin
            result_o.li_class = rlc_pkg::LIC_PIGGYBACK;
          end else if (li == rlc_pkg::LI_PADDING) begin
            result_o.li_class = rlc_pkg::LIC_PADDING;
          end else begin
            result_o.li_class = rlc_pkg::LIC_ORDINARY;
          end
          if (!b[0]) begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: result_o.byte_role = rlc_pkg::ROLE_PAYLOAD;
        PH_CTRL:    result_o.byte_role = rlc_pkg::ROLE_CTRL_BODY;
        default:    result_o.byte_role = rlc_pkg::ROLE_UNEXPECTED;
      endcase
    end

    // kind reflects the PDU being parsed, including a new one starting now
    result_o.pdu_kind = kind_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      held_q  <= '0;
      kind_q  <= rlc_pkg::KIND_UM_DATA;
    end else if (advance_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      kind_q  <= kind_d;
    end
  end

endmodule

>>> rtl/rlc_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_out_reg
// Result register: holds one tagged octet until the sink takes it.
// ----------------------------------------------------------------------------
module rlc_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rlc_pkg::out_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rlc_pkg::out_item_t out_item_o
);

  logic               valid_q;
  rlc_pkg::out_item_t item_q;

  assign in_stall_o = valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

>>> rtl/rlc_pdu_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_pdu_header_parser
// RLC PDU header parser: tags each octet of a UM or AM PDU with its role and
// extracts sequence number, poll, header extension and length indicators.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid_i/in_stall_o  in_item_i  (pdu_byte, start)
//   out       source     out_valid_o/out_stall_i out_item_o (tagged octet)
//   cfg       sink       cfg_valid_i/cfg_ready_o cfg_data_i (rlc_mode)
//
// One octet per cycle sustained while the output does not stall; each octet passes
// through the input register, decode and the result register.
// Reset clears both stages and returns the parser to expecting a first octet.
// A stall at the output holds the result register and backs up to the input
// register; the block keeps accepting while the result register drains.
// cfg is always ready; the mode is sampled on each start-of-PDU octet.
// ----------------------------------------------------------------------------
module rlc_pdu_header_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rlc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rlc_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);

  logic               mode_q;
  logic               dec_valid;
  logic               dec_stall;
  rlc_pkg::in_item_t  dec_item;
  rlc_pkg::out_item_t dec_result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rlc_pkg::MODE_UM;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  rlc_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (dec_valid),
    .out_stall_i (dec_stall),
    .out_item_o  (dec_item)
  );

  rlc_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (dec_valid && !dec_stall),
    .rlc_mode_i (mode_q),
    .item_i     (dec_item),
    .result_o   (dec_result)
  );

  rlc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_stall_o  (dec_stall),
    .in_item_i   (dec_result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // only header octets may carry the invalid flag
  a_invalid_on_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.header_invalid |->
      (out_item_o.byte_role == rlc_pkg::ROLE_FIRST ||
       out_item_o.byte_role == rlc_pkg::ROLE_AM_SECOND))
    else $error("header_invalid on a non-header octet");

  a_li_class_on_li: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.li_class != rlc_pkg::LIC_ORDINARY) |->
      out_item_o.byte_role == rlc_pkg::ROLE_LI)
    else $error("li_class set outside a length indicator octet");

  a_poll_on_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.poll_flag |->
      out_item_o.byte_role == rlc_pkg::ROLE_AM_SECOND &&
      out_item_o.pdu_kind == rlc_pkg::KIND_AM_DATA)
    else $error("poll flag outside second AM data header octet");

  a_start_is_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_valid && !dec_stall && dec_item.start_of_pdu |=>
      out_valid_o && out_item_o.byte_role == rlc_pkg::ROLE_FIRST)
    else $error("start-of-PDU octet not tagged as first header octet");

endmodule

>>> bench/rlc_pdu_header_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_pdu_header_parser_checker
// Passive checker for the RLC PDU header parser. It watches the octet, tag
// and mode channels, keeps its own copy of the parse state, predicts the tag
// of every accepted octet and compares each accepted tag with the oldest
// prediction. Reports the mismatch count and the number of tags outstanding.
// ----------------------------------------------------------------------------
module rlc_pdu_header_parser_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  rlc_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  rlc_pkg::out_item_t out_item_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);

  typedef enum logic [2:0] {
    AWAIT_FIRST,
    AWAIT_AM_SECOND,
    IN_LI_CHAIN,
    IN_PAYLOAD,
    IN_CTRL_BODY,
    IN_BAD_PDU
  } parse_phase_e;

  logic               mode;
  parse_phase_e       phase;
  logic [7:0]         held_octet;
  logic [1:0]         held_kind;
  rlc_pkg::out_item_t expected_tags[$];
  int                 mismatch_count = 0;

  function automatic string fmt_tag(input rlc_pkg::out_item_t t);
    return $sformatf({"role %0d kind %0d sn %0d poll %0d he %0d li %0d ",
                      "cls %0d e %0d ct %0d sufi %0d inv %0d"},
                     t.byte_role, t.pdu_kind, t.seq_number, t.poll_flag,
                     t.header_extension, t.length_indicator, t.li_class,
                     t.ext_flag, t.control_type, t.sufi_type, t.header_invalid);
  endfunction

  // advances the parse state by one octet and returns its tag
  function automatic rlc_pkg::out_item_t parse_octet(input rlc_pkg::in_item_t it);
    rlc_pkg::out_item_t t;
    logic [15:0] hdr;
    logic [2:0]  ct;
    logic [6:0]  li;
    t = '0;
    if (it.start_of_pdu) begin
      t.byte_role = rlc_pkg::ROLE_FIRST;
      held_octet  = it.pdu_byte;
      if (mode == rlc_pkg::MODE_UM) begin
        held_kind    = rlc_pkg::KIND_UM_DATA;
        t.seq_number = {5'd0, it.pdu_byte[7:1]};
        t.ext_flag   = it.pdu_byte[0];
        phase        = it.pdu_byte[0] ? IN_LI_CHAIN : IN_PAYLOAD;
      end else if (it.pdu_byte[7]) begin
        held_kind = rlc_pkg::KIND_AM_DATA;
        phase     = AWAIT_AM_SECOND;
      end else begin
        ct             = it.pdu_byte[6:4];
        held_kind      = rlc_pkg::KIND_AM_CTRL;
        t.control_type = ct;
        if (ct == rlc_pkg::CT_STATUS) t.sufi_type = it.pdu_byte[3:0];
        if (ct > rlc_pkg::CT_RESET_ACK) begin
          t.header_invalid = 1'b1;
          phase            = IN_BAD_PDU;
        end else begin
          phase = IN_CTRL_BODY;
        end
      end
    end else begin
      case (phase)
        AWAIT_AM_SECOND: begin
          hdr                = {held_octet, it.pdu_byte};
          t.byte_role        = rlc_pkg::ROLE_AM_SECOND;
          t.seq_number       = hdr[14:3];
          t.poll_flag        = hdr[2];
          t.header_extension = hdr[1:0];
          if (hdr[1:0] == rlc_pkg::HE_PAYLOAD) begin
            phase = IN_PAYLOAD;
          end else if (hdr[1:0] == rlc_pkg::HE_LI) begin
            phase = IN_LI_CHAIN;
          end else begin
            t.header_invalid = 1'b1;
            phase            = IN_BAD_PDU;
          end
        end
        IN_LI_CHAIN: begin
          li                 = it.pdu_byte[7:1];
          t.byte_role        = rlc_pkg::ROLE_LI;
          t.length_indicator = li;
          t.ext_flag         = it.pdu_byte[0];
          case (li)
            rlc_pkg::LI_RESERVED:  t.li_class = rlc_pkg::LIC_RESERVED;
            rlc_pkg::LI_PIGGYBACK: t.li_class = rlc_pkg::LIC_PIGGYBACK;
            rlc_pkg::LI_PADDING:   t.li_class = rlc_pkg::LIC_PADDING;
            default:               t.li_class = rlc_pkg::LIC_ORDINARY;
          endcase
          if (!it.pdu_byte[0]) phase = IN_PAYLOAD;
        end
        IN_PAYLOAD:   t.byte_role = rlc_pkg::ROLE_PAYLOAD;
        IN_CTRL_BODY: t.byte_role = rlc_pkg::ROLE_CTRL_BODY;
        default:      t.byte_role = rlc_pkg::ROLE_UNEXPECTED;
      endcase
    end
    t.pdu_kind = held_kind;
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rlc_pkg::out_item_t want;
    if (!rst_ni) begin
      mode       = rlc_pkg::MODE_UM;
      phase      = AWAIT_FIRST;
      held_octet = '0;
      held_kind  = rlc_pkg::KIND_UM_DATA;
      expected_tags.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // retire before predicting: a tag never leaves in the cycle its octet enters
      if (out_valid_i && !out_stall_i) begin
        if (expected_tags.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: tag with none expected: %s", $realtime, fmt_tag(out_item_i));
        end else begin
          want = expected_tags.pop_front();
          if (out_item_i !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: tag mismatch", $realtime);
              $display("  expected %s", fmt_tag(want));
              $display("  actual   %s", fmt_tag(out_item_i));
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) mode = cfg_data_i;
      if (in_valid_i && !in_stall_i) expected_tags.push_back(parse_octet(in_item_i));
      pending_o <= expected_tags.size();
      errors_o  <= mismatch_count;
    end
  end

endmodule

>>> bench/rlc_pdu_header_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_pdu_header_parser_test
// Testbench for the RLC PDU header parser. A directed run over the UM and AM
// header forms is followed by randomised PDUs, mostly well formed with random
// content and some noise, across several mode settings. Both sides idle at
// random; the receiver holds off once for a long stretch. Checking is done by
// the checker module instantiated beside the parser.
// ----------------------------------------------------------------------------
module rlc_pdu_header_parser_test;

  localparam int OCTET_TARGET   = 1000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 120;
  localparam int HOLD_AFTER     = 250;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  rlc_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  rlc_pkg::out_item_t out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_data;

  int   errors;
  int   pending;
  int   octets_sent  = 0;
  int   idle_cycles  = 0;
  logic cur_mode;
  bit   tx_calm      = 1'b0;
  bit   rx_calm      = 1'b0;

  rlc_pdu_header_parser dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  rlc_pdu_header_parser_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_item_i (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ends the run if no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("== FAIL ==");
          $finish;
        end
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic put_octet(input logic [7:0] b, input logic s);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{pdu_byte: b, start_of_pdu: s};
    do @(posedge clk); while (in_stall);
    octets_sent++;
  endtask

  // pending is registered, hence the first wait
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = m;
  endtask

  task automatic send_li_chain();
    int n;
    logic [6:0] li;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 30) li = 7'($urandom_range(125, 127));
      else li = 7'($urandom_range(0, 127));
      put_octet({li, (i != n - 1) ? 1'b1 : 1'b0}, 1'b0);
    end
  endtask

  task automatic send_payload(input int maxlen);
    repeat ($urandom_range(0, maxlen)) put_octet(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_pdu();
    int r;
    logic [7:0] first;
    logic [1:0] he;
    logic [2:0] ct;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
    if (r < 8) begin
      // noise: stray octets, start marks at random
      repeat ($urandom_range(1, 4))
        put_octet(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else if (cur_mode == rlc_pkg::MODE_UM) begin
      first = 8'($urandom_range(0, 255));
      put_octet(first, 1'b1);
      if (first[0]) send_li_chain();
      send_payload(5);
    end else if (r < 70) begin
      put_octet({1'b1, 7'($urandom_range(0, 127))}, 1'b1);
      if ($urandom_range(0, 99) < 85) he = 2'($urandom_range(0, 1));
      else he = 2'($urandom_range(2, 3));
      put_octet({6'($urandom_range(0, 63)), he}, 1'b0);
      if (he == rlc_pkg::HE_LI) send_li_chain();
      send_payload((he > rlc_pkg::HE_LI) ? 2 : 5);
    end else begin
      if ($urandom_range(0, 99) < 80) ct = 3'($urandom_range(0, 2));
      else ct = 3'($urandom_range(3, 7));
      put_octet({1'b0, ct, 4'($urandom_range(0, 15))}, 1'b1);
      send_payload(3);
    end
  endtask

  // receiver: random stalls, calm stretches, one long hold-off
  initial begin : receiver
    int  stall_left;
    int  outs;
    bit  held;
    stall_left = 0;
    outs       = 0;
    held       = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) outs++;
      if (!held && outs >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
        if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
      end
    end
  end

  initial begin : stimulus
    int quota;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = rlc_pkg::MODE_UM;
    cur_mode  = rlc_pkg::MODE_UM;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // UM after reset: stray octet, LI chain through the special values
    put_octet(8'hFF, 1'b0);
    put_octet(8'hFF, 1'b1);
    put_octet(8'hFB, 1'b0);
    put_octet(8'hFD, 1'b0);
    put_octet(8'hFF, 1'b0);
    put_octet(8'h00, 1'b0);
    put_octet(8'hAA, 1'b0);
    put_octet(8'h00, 1'b1);

    // mode only bites at the next start mark
    write_mode(rlc_pkg::MODE_AM);
    put_octet(8'h55, 1'b0);

    // AM data: invalid extension, payload, LI chain, other invalid extension
    put_octet(8'hFF, 1'b1);
    put_octet(8'hFF, 1'b0);
    put_octet(8'h80, 1'b1);
    put_octet(8'h00, 1'b0);
    put_octet(8'hA5, 1'b1);
    put_octet(8'h5D, 1'b0);
    put_octet(8'h03, 1'b0);
    put_octet(8'hFE, 1'b0);
    put_octet(8'hC0, 1'b1);
    put_octet(8'h06, 1'b0);

    // AM control: status, reset, reset ack, bad types
    put_octet(8'h0F, 1'b1);
    put_octet(8'h77, 1'b0);
    put_octet(8'h10, 1'b1);
    put_octet(8'h20, 1'b1);
    put_octet(8'h30, 1'b1);
    put_octet(8'h44, 1'b0);
    put_octet(8'h7A, 1'b1);

    for (int ph = 0; octets_sent < OCTET_TARGET; ph++) begin
      if (ph == 0) write_mode(rlc_pkg::MODE_UM);
      else if (ph == 1) write_mode(rlc_pkg::MODE_AM);
      else write_mode(1'($urandom_range(0, 1)));
      quota = octets_sent + $urandom_range(80, 160);
      while (octets_sent < quota) send_pdu();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
